[src/bps_pkg.sv]
// Shared widths, constants and types for the block packet segmenter.
package bps_pkg;

  localparam int LEN_W = 20;
  localparam int OFS_W = 32;

  localparam int TARGET_PIECE_BYTES_DEF = 10240;
  localparam int MAX_BLOCK_BYTES_DEF    = 184320;

  localparam int RESULT_LIMIT = 18;
  localparam int CNT_W        = $clog2(RESULT_LIMIT);

  // Load command from the sequencer to the piece emitter.
  typedef struct packed {
    logic             load;
    logic             big;
    logic [LEN_W-1:0] togo;
    logic [LEN_W-1:0] size;
    logic [OFS_W-1:0] ofs_end;
  } bps_load_t;

endpackage

[src/bps_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module bps_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bps_pkg::LEN_W-1:0] dividend,
  input  logic [bps_pkg::LEN_W-1:0] divisor,
  output logic                      done,
  output logic [bps_pkg::LEN_W-1:0] quotient
);
  import bps_pkg::*;

  localparam int STEP_W = $clog2(LEN_W + 1);

  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  quo_r, quo_nxt;
  logic [LEN_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [LEN_W:0]    trial;

  assign trial = {rem_r, quo_r[LEN_W-1]} - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(LEN_W);
    end else if (step_r != '0) begin
      if (!trial[LEN_W]) begin
        rem_nxt = trial[LEN_W-1:0];
        quo_nxt = {quo_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[LEN_W-2:0], quo_r[LEN_W-1]};
        quo_nxt = {quo_r[LEN_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      done_nxt = (step_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/bps_emit.sv]
// Piece emitter: walks the block and issues one piece beat per cycle while out_stall is low.
module bps_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bps_pkg::bps_load_t        cmd,
  output logic                      busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bps_pkg::OFS_W-1:0] out_piece_start,
  output logic [bps_pkg::OFS_W-1:0] out_piece_end,
  output logic [bps_pkg::LEN_W-1:0] out_piece_length,
  output logic                      out_last_piece,
  output logic                      out_too_large
);
  import bps_pkg::*;

  logic             active_r, active_nxt;
  logic             big_r, big_nxt;
  logic [LEN_W-1:0] togo_r, togo_nxt;
  logic [LEN_W-1:0] size_r, size_nxt;
  logic [OFS_W-1:0] end_r, end_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [OFS_W-1:0] ostart_r, ostart_nxt;
  logic [OFS_W-1:0] oend_r, oend_nxt;
  logic [LEN_W-1:0] olen_r, olen_nxt;
  logic             olast_r, olast_nxt;
  logic             obig_r, obig_nxt;

  logic             fire;
  logic             take_all;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] togo_left;

  assign fire      = active_r && (!ovalid_r || !out_stall);
  // remainder shorter than two pieces, or the result cap reached
  assign take_all  = ({1'b0, togo_r} < {size_r, 1'b0}) ||
                     (cnt_r == CNT_W'(RESULT_LIMIT - 1));
  assign plen      = take_all ? togo_r : size_r;
  assign togo_left = togo_r - plen;

  always_comb begin
    active_nxt = active_r;
    big_nxt    = big_r;
    togo_nxt   = togo_r;
    size_nxt   = size_r;
    end_nxt    = end_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && out_stall;
    ostart_nxt = ostart_r;
    oend_nxt   = oend_r;
    olen_nxt   = olen_r;
    olast_nxt  = olast_r;
    obig_nxt   = obig_r;
    if (cmd.load) begin
      active_nxt = 1'b1;
      big_nxt    = cmd.big;
      togo_nxt   = cmd.togo;
      size_nxt   = cmd.size;
      end_nxt    = cmd.ofs_end;
      cnt_nxt    = '0;
    end else if (fire) begin
      ovalid_nxt = 1'b1;
      if (big_r) begin
        ostart_nxt = '0;
        oend_nxt   = '0;
        olen_nxt   = '0;
        olast_nxt  = 1'b1;
        obig_nxt   = 1'b1;
        active_nxt = 1'b0;
      end else begin
        ostart_nxt = end_r - {{(OFS_W-LEN_W){1'b0}}, togo_r};
        oend_nxt   = end_r - {{(OFS_W-LEN_W){1'b0}}, togo_left};
        olen_nxt   = plen;
        olast_nxt  = (togo_left == '0);
        obig_nxt   = 1'b0;
        togo_nxt   = togo_left;
        cnt_nxt    = cnt_r + CNT_W'(1);
        active_nxt = (togo_left != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
    big_r    <= big_nxt;
    togo_r   <= togo_nxt;
    size_r   <= size_nxt;
    end_r    <= end_nxt;
    cnt_r    <= cnt_nxt;
    ostart_r <= ostart_nxt;
    oend_r   <= oend_nxt;
    olen_r   <= olen_nxt;
    olast_r  <= olast_nxt;
    obig_r   <= obig_nxt;
  end

  assign busy             = active_r;
  assign out_valid        = ovalid_r;
  assign out_piece_start  = ostart_r;
  assign out_piece_end    = oend_r;
  assign out_piece_length = olen_r;
  assign out_last_piece   = olast_r;
  assign out_too_large    = obig_r;

endmodule

[src/block_packet_segmenter_unit.sv]
// Block packet segmenter: splits a requested block into packet piece descriptors.
//
// Input channel (in_valid/in_stall): one beat carries a block length and its
// exclusive end offset. Output channel (out_valid/out_stall): one beat per
// piece with start, end, length, last flag and an oversize flag.
// A block longer than the target piece size runs two passes of a bit-serial
// divider (piece count, then piece size); blocks up to the target size and
// oversized blocks skip the divider. Pieces then leave at one per cycle while
// out_stall is low, up to 18 per block. A zero-length block is taken and
// yields no beat; an oversized block yields a single beat with too_large set
// and zero fields. One block is in flight at a time: in_stall is high from
// acceptance until the cycle after the last piece has moved to the output
// register. The output register holds its beat while out_stall is high; the
// emitter simply waits. rst_n is synchronous, active low, and empties the
// block.
module block_packet_segmenter_unit #(
  parameter int TARGET_PIECE_BYTES = bps_pkg::TARGET_PIECE_BYTES_DEF,
  parameter int MAX_BLOCK_BYTES    = bps_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [bps_pkg::LEN_W-1:0] in_block_length,
  input  logic [bps_pkg::OFS_W-1:0] in_block_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bps_pkg::OFS_W-1:0] out_piece_start,
  output logic [bps_pkg::OFS_W-1:0] out_piece_end,
  output logic [bps_pkg::LEN_W-1:0] out_piece_length,
  output logic                      out_last_piece,
  output logic                      out_too_large
);
  import bps_pkg::*;

  localparam logic [LEN_W-1:0] TARGET_LEN = LEN_W'(TARGET_PIECE_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_BLOCK_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV1 = 4'b0010,
    ST_DIV2 = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [OFS_W-1:0] end_r, end_nxt;

  logic             div_start;
  logic [LEN_W-1:0] div_dividend;
  logic [LEN_W-1:0] div_divisor;
  logic             div_done;
  logic [LEN_W-1:0] div_quo;
  logic             emit_busy;
  bps_load_t        cmd;
  logic             in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    end_nxt      = end_r;
    div_start    = 1'b0;
    div_dividend = len_r;
    div_divisor  = div_quo;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_block_length != '0) begin
          len_nxt = in_block_length;
          end_nxt = in_block_end;
          if (in_block_length > MAX_LEN) begin
            cmd.load  = 1'b1;
            cmd.big   = 1'b1;
            state_nxt = ST_EMIT;
          end else if (in_block_length <= TARGET_LEN) begin
            cmd.load    = 1'b1;
            cmd.togo    = in_block_length;
            cmd.size    = in_block_length;
            cmd.ofs_end = in_block_end;
            state_nxt   = ST_EMIT;
          end else begin
            div_start    = 1'b1;
            div_dividend = in_block_length;
            div_divisor  = TARGET_LEN;
            state_nxt    = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        // piece count ready: divide the length by it
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          cmd.load    = 1'b1;
          cmd.togo    = len_r;
          cmd.size    = div_quo;
          cmd.ofs_end = end_r;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    len_r <= len_nxt;
    end_r <= end_nxt;
  end

  bps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  bps_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .busy             (emit_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_piece_start  (out_piece_start),
    .out_piece_end    (out_piece_end),
    .out_piece_length (out_piece_length),
    .out_last_piece   (out_last_piece),
    .out_too_large    (out_too_large)
  );

endmodule

[tb/sv/piece_checker.sv]
// Piece checker: predicts the piece beats of each block and compares the result channel.
module piece_checker #(
  parameter int TARGET_PIECE_BYTES = bps_pkg::TARGET_PIECE_BYTES_DEF,
  parameter int MAX_BLOCK_BYTES    = bps_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [bps_pkg::LEN_W-1:0] in_block_length,
  input  logic [bps_pkg::OFS_W-1:0] in_block_end,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [bps_pkg::OFS_W-1:0] out_piece_start,
  input  logic [bps_pkg::OFS_W-1:0] out_piece_end,
  input  logic [bps_pkg::LEN_W-1:0] out_piece_length,
  input  logic                      out_last_piece,
  input  logic                      out_too_large,
  output int                        mismatches,
  output int                        pieces_due
);
  import bps_pkg::*;

  typedef struct packed {
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] end_ofs;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             big;
  } piece_t;

  piece_t piece_queue[$];
  int     fault_count = 0;
  int     due_count   = 0;

  assign mismatches = fault_count;
  assign pieces_due = due_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] PIECE ERROR: %s", $realtime, msg);
    fault_count++;
  endtask

  // Walk the block from its start; the tail takes whatever is left once
  // fewer than two nominal pieces remain or the piece limit is reached.
  function automatic void split_block(input logic [LEN_W-1:0] blk_len,
                                      input logic [OFS_W-1:0] blk_end);
    int unsigned togo;
    int unsigned size;
    int          n;
    piece_t      p;
    togo = blk_len;
    n    = 0;
    if (togo == 0) return;
    if (togo > MAX_BLOCK_BYTES) begin
      p = '{start_ofs: '0, end_ofs: '0, len: '0, last: 1'b1, big: 1'b1};
      piece_queue.push_back(p);
      return;
    end
    size = (togo > TARGET_PIECE_BYTES) ? togo / (togo / TARGET_PIECE_BYTES) : togo;
    while (togo != 0) begin
      if (togo < size * 2 || n == RESULT_LIMIT - 1) size = togo;
      togo -= size;
      p.end_ofs   = blk_end - togo;
      p.start_ofs = blk_end - togo - size;
      p.len       = size[LEN_W-1:0];
      p.last      = (togo == 0);
      p.big       = 1'b0;
      piece_queue.push_back(p);
      n++;
    end
  endfunction

  task automatic check_beat();
    piece_t got;
    piece_t want;
    string  diffs;
    got = '{start_ofs: out_piece_start, end_ofs: out_piece_end, len: out_piece_length,
            last: out_last_piece, big: out_too_large};
    if (piece_queue.size() == 0) begin
      report_mismatch($sformatf("beat with no piece due: start %h end %h len %0d last %b big %b",
                                got.start_ofs, got.end_ofs, got.len, got.last, got.big));
      return;
    end
    want  = piece_queue.pop_front();
    diffs = "";
    if (got.start_ofs != want.start_ofs)
      diffs = {diffs, $sformatf(" start %h/%h", got.start_ofs, want.start_ofs)};
    if (got.end_ofs != want.end_ofs)
      diffs = {diffs, $sformatf(" end %h/%h", got.end_ofs, want.end_ofs)};
    if (got.len != want.len)
      diffs = {diffs, $sformatf(" len %0d/%0d", got.len, want.len)};
    if (got.last != want.last)
      diffs = {diffs, $sformatf(" last %b/%b", got.last, want.last)};
    if (got.big != want.big)
      diffs = {diffs, $sformatf(" too_large %b/%b", got.big, want.big)};
    if (diffs != "") report_mismatch({"got/expected:", diffs});
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) split_block(in_block_length, in_block_end);
      if (out_valid && !out_stall) check_beat();
    end
    due_count <= piece_queue.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the block packet segmenter: stimulus, stalls, watchdog and verdict.
module tb_top;
  import bps_pkg::*;

  localparam int TARGET         = TARGET_PIECE_BYTES_DEF;
  localparam int MAX_BLK        = MAX_BLOCK_BYTES_DEF;
  localparam int RESET_CYCLES   = 7;
  localparam int ITEMS_PER_PASS = 62;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 3000;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [LEN_W-1:0] in_block_length = '0;
  logic [OFS_W-1:0] in_block_end    = '0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [OFS_W-1:0] out_piece_start;
  logic [OFS_W-1:0] out_piece_end;
  logic [LEN_W-1:0] out_piece_length;
  logic             out_last_piece;
  logic             out_too_large;

  int mismatches;
  int pieces_due;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  block_packet_segmenter_unit #(
    .TARGET_PIECE_BYTES(TARGET),
    .MAX_BLOCK_BYTES   (MAX_BLK)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_block_length  (in_block_length),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_piece_start  (out_piece_start),
    .out_piece_end    (out_piece_end),
    .out_piece_length (out_piece_length),
    .out_last_piece   (out_last_piece),
    .out_too_large    (out_too_large)
  );

  piece_checker #(
    .TARGET_PIECE_BYTES(TARGET),
    .MAX_BLOCK_BYTES   (MAX_BLK)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_block_length  (in_block_length),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_piece_start  (out_piece_start),
    .out_piece_end    (out_piece_end),
    .out_piece_length (out_piece_length),
    .out_last_piece   (out_last_piece),
    .out_too_large    (out_too_large),
    .mismatches       (mismatches),
    .pieces_due       (pieces_due)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Gives up when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_block(input logic [LEN_W-1:0] blk_len, input logic [OFS_W-1:0] blk_end);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_block_length <= blk_len;
    in_block_end    <= blk_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return LEN_W'($urandom_range((1 << LEN_W) - 1, MAX_BLK + 1));
    if (r < 35) return LEN_W'($urandom_range(TARGET, 1));
    if (r < 55) begin
      // around a multiple of the target size, where the piece count steps
      k = $urandom_range(18, 1);
      return LEN_W'(k * TARGET + $urandom_range(2) - 1);
    end
    return LEN_W'($urandom_range(MAX_BLK, TARGET + 1));
  endfunction

  function automatic logic [OFS_W-1:0] pick_end();
    int r;
    r = $urandom_range(99);
    if (r < 15) return OFS_W'($urandom_range(MAX_BLK));           // start wraps below zero
    if (r < 25) return ~OFS_W'($urandom_range(MAX_BLK));          // near the top
    return OFS_W'($urandom);
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: length boundaries, oversize, offset wrap, bit patterns
    send_block(20'd0,        32'd1234);
    send_block(20'd1,        32'd0);
    send_block(20'd1,        32'hFFFF_FFFF);
    send_block(20'd10240,    32'd10240);
    send_block(20'd10241,    32'd0);
    send_block(20'd20479,    32'd100);
    send_block(20'd20480,    32'd20480);
    send_block(20'd20481,    32'd5);
    send_block(20'd30719,    32'h0001_0000);
    send_block(20'd30720,    32'h8000_0000);
    send_block(20'd184319,   32'd0);
    send_block(20'd184320,   32'd184320);
    send_block(20'd184320,   32'd7);
    send_block(20'd184321,   32'h1234_5678);
    send_block(20'hFFFFF,    32'hFFFF_FFFF);
    send_block(20'h80000,    32'd0);
    send_block(20'h55555,    32'h5555_5555);
    send_block(20'h0AAAA,    32'hAAAA_AAAA);
    send_block(20'h05555,    32'h5555_5555);
    send_block(20'd5000,     32'd3000);
    send_block(20'd100000,   32'd99999);
    send_block(20'd0,        32'hFFFF_FFFF);
    send_block(20'd174081,   32'hFFFF_FFF0);

    // random: no idling, sender gaps, receiver stalls, both
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      for (int i = 0; i < ITEMS_PER_PASS; i++) send_block(pick_length(), pick_end());
    end
    in_valid <= 1'b0;

    // wait so the count reflects the final accepted block
    @(posedge clk);
    while (pieces_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pieces_due == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
src/bps_pkg.sv
src/bps_div.sv
src/bps_emit.sv
src/block_packet_segmenter_unit.sv
tb/sv/piece_checker.sv
tb/sv/tb_top.sv
